/* sv/haversine_polyline_length_macros.svh */
// Assertion macros used by the checker file.
`ifndef HAVERSINE_POLYLINE_LENGTH_MACROS_SVH
`define HAVERSINE_POLYLINE_LENGTH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HPL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpl assertion failed");

// Next-cycle implication, disabled during reset.
`define HPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpl assertion failed");

`endif

/* sv/hpl_pkg.sv */
// ----------------------------------------------------------------------------
// hpl_pkg
// Types and constants of the haversine polyline length block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpl_pkg;

  localparam int          ANG_W       = 32;
  localparam int          CW          = 34;
  localparam int          RAD_W       = 40;
  localparam int          SEG_W       = 40;
  localparam int          TOT_W       = 48;
  localparam int          QUEUE_DEPTH = 2;
  localparam logic [37:0] RECIP45     = 38'd195468733827;
  localparam logic [CW-1:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] QONE        = 31'd1073741824;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 40'd417529856000;

  typedef struct packed {
    logic [ANG_W-1:0] angle_lat;
    logic [ANG_W-1:0] angle_dlat;
    logic [ANG_W-1:0] angle_dlon;
    logic             has_prev;
    logic             last;
  } queue_item_t;

  function automatic logic [CW-1:0] cordic_angle(input int idx);
    logic [CW-1:0] v;
    begin
      case (idx)
        0: v = 34'd536870912;   1: v = 34'd316933406;
        2: v = 34'd167458907;   3: v = 34'd85004756;
        4: v = 34'd42667331;    5: v = 34'd21354465;
        6: v = 34'd10679838;    7: v = 34'd5340245;
        8: v = 34'd2670163;     9: v = 34'd1335087;
        10: v = 34'd667544;     11: v = 34'd333772;
        12: v = 34'd166886;     13: v = 34'd83443;
        14: v = 34'd41722;      15: v = 34'd20861;
        16: v = 34'd10430;      17: v = 34'd5215;
        18: v = 34'd2608;       19: v = 34'd1304;
        20: v = 34'd652;        21: v = 34'd326;
        22: v = 34'd163;        23: v = 34'd81;
        24: v = 34'd41;         25: v = 34'd20;
        26: v = 34'd10;         27: v = 34'd5;
        28: v = 34'd3;          29: v = 34'd1;
        30: v = 34'd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

/* sv/hpl_if.sv */
// ----------------------------------------------------------------------------
// hpl_in_if / hpl_out_if
// Valid/ready channels for points and for length results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hpl_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude;
  logic signed [31:0] longitude;
  logic               last_point;
  modport source (output valid, latitude, longitude, last_point, input ready);
  modport sink   (input valid, latitude, longitude, last_point, output ready);
endinterface

interface hpl_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] segment_length;
  logic [47:0] total_length;
  logic        line_done;
  modport source (output valid, segment_length, total_length, line_done, input ready);
  modport sink   (input valid, segment_length, total_length, line_done, output ready);
endinterface

/* sv/hpl_front.sv */
// ----------------------------------------------------------------------------
// hpl_front
// Accepts points, keeps the previous point and turns degrees into binary
// angles by reciprocal multiplication with 1/45 on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpl_front import hpl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic               in_last_point,
  output logic               push,
  input  logic               queue_full,
  output queue_item_t        push_item
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t            state_r;
  logic signed [30:0] prev_lat_r;
  logic signed [31:0] prev_lon_r;
  logic               have_prev_r;
  logic               has_prev_r;
  logic               last_r;
  logic [1:0]         sel_r;
  logic               half_r;
  logic [31:0]        mag_r [3];
  logic               neg_r [3];
  logic [50:0]        lo_r;
  logic [ANG_W-1:0]   quo_r [3];

  logic signed [32:0] dif [3];
  logic [31:0]        mul_a;
  logic [18:0]        mul_b;
  logic [50:0]        prod;
  logic [69:0]        sum;
  logic [ANG_W-1:0]   quo;
  logic [ANG_W-1:0]   ang [3];

  assign in_ready = (state_r == F_IDLE);
  assign push     = (state_r == F_PUSH) && !queue_full;

  always_comb begin
    dif[0] = 33'(in_latitude);
    dif[1] = 33'(in_latitude) - 33'(prev_lat_r);
    dif[2] = 33'(in_longitude) - 33'(prev_lon_r);
    case (sel_r)
      2'd0:    mul_a = mag_r[0];
      2'd1:    mul_a = mag_r[1];
      default: mul_a = mag_r[2];
    endcase
    mul_b = half_r ? RECIP45[37:19] : RECIP45[18:0];
    prod  = 51'(mul_a) * 51'(mul_b);
    sum   = {prod, 19'b0} + 70'(lo_r);
    quo   = (sel_r == 2'd0) ? sum[68:37] : sum[69:38];
    for (int k = 0; k < 3; k++) begin
      ang[k] = neg_r[k] ? (ANG_W'(0) - quo_r[k]) : quo_r[k];
    end
    push_item.angle_lat  = ang[0];
    push_item.angle_dlat = ang[1];
    push_item.angle_dlon = ang[2];
    push_item.has_prev   = has_prev_r;
    push_item.last       = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      have_prev_r <= 1'b0;
      prev_lat_r  <= '0;
      prev_lon_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            for (int k = 0; k < 3; k++) begin
              neg_r[k] <= dif[k][32];
              mag_r[k] <= dif[k][32] ? 32'(-dif[k]) : dif[k][31:0];
            end
            has_prev_r  <= have_prev_r;
            last_r      <= in_last_point;
            have_prev_r <= !in_last_point;
            prev_lat_r  <= in_latitude;
            prev_lon_r  <= in_longitude;
            sel_r       <= 2'd0;
            half_r      <= 1'b0;
            state_r     <= F_DIV;
          end
        end
        F_DIV: begin
          half_r <= !half_r;
          if (!half_r) begin
            lo_r <= prod;
          end else begin
            case (sel_r)
              2'd0:    quo_r[0] <= quo;
              2'd1:    quo_r[1] <= quo;
              default: quo_r[2] <= quo;
            endcase
            if (sel_r == 2'd2) state_r <= F_PUSH;
            else               sel_r   <= sel_r + 2'd1;
          end
        end
        F_PUSH: begin
          if (!queue_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* sv/hpl_queue.sv */
// ----------------------------------------------------------------------------
// hpl_queue
// Short queue of classified points between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpl_queue import hpl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output queue_item_t pop_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  queue_item_t   mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full      = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

/* sv/hpl_back.sv */
// ----------------------------------------------------------------------------
// hpl_back
// Haversine distance on one shared CORDIC unit, two serial square roots and
// one shared multiplier; keeps the running total and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpl_back import hpl_pkg::*; #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [RAD_W-1:0]  cfg_wr_data,
  input  logic              q_not_empty,
  input  queue_item_t       q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEG_W-1:0]  out_segment_length,
  output logic [TOT_W-1:0]  out_total_length,
  output logic              out_line_done
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_CORD, B_CDONE, B_SQ1, B_SQ2, B_CC, B_TT,
    B_HC, B_SQRT, B_VLOAD, B_TH, B_P1, B_P2, B_SEG, B_FIN
  } bstate_t;

  bstate_t                state_r;
  queue_item_t            item_r;
  logic [1:0]             sel_r;
  logic                   vec_r, flip_r;
  logic [STEP_W-1:0]      step_r;
  logic signed [CW-1:0]   x_r, y_r, z_r;
  logic signed [CW-1:0]   cos_now_r, prev_cos_r, s1_r, s2_r, sq1_r, sq2_r, cc_r, t_r;
  logic [63:0]            na_r, nb_r, ra_r, rb_r, sbit_r;
  logic [4:0]             sq_cnt_r;
  logic [30:0]            zc_r;
  logic [34:0]            theta_r;
  logic [54:0]            p1_r, p2_r;
  logic [SEG_W-1:0]       seg_r;
  logic [TOT_W-1:0]       total_r;
  logic [RAD_W-1:0]       radius_r;
  logic                   out_valid_r, out_done_r;
  logic [SEG_W-1:0]       out_seg_r;
  logic [TOT_W-1:0]       out_tot_r;

  logic [ANG_W-1:0]       rot_a, rot_a2;
  logic                   rot_flip;
  logic signed [CW-1:0]   xs, ys, ang_t, c_res, s_res;
  logic                   pos;
  logic signed [35:0]     mul_a;
  logic signed [32:0]     mul_b;
  logic signed [68:0]     prod;
  logic signed [CW:0]     h_sum;
  logic [30:0]            h_cl;
  logic [63:0]            ta, tb;
  logic [55:0]            seg_sum;
  logic [TOT_W:0]         tot_sum;
  logic [TOT_W-1:0]       tot_new;

  assign pop                = (state_r == B_IDLE) && q_not_empty;
  assign out_valid          = out_valid_r;
  assign out_segment_length = out_seg_r;
  assign out_total_length   = out_tot_r;
  assign out_line_done      = out_done_r;

  always_comb begin
    case (sel_r)
      2'd0:    rot_a = item_r.angle_lat;
      2'd1:    rot_a = item_r.angle_dlat;
      default: rot_a = item_r.angle_dlon;
    endcase
    rot_flip = rot_a[31] ^ rot_a[30];
    rot_a2   = rot_flip ? {~rot_a[31], rot_a[30:0]} : rot_a;

    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    ang_t = cordic_angle(int'(step_r));
    pos   = vec_r ? !(y_r > 0) : !z_r[CW-1];
    c_res = flip_r ? -x_r : x_r;
    s_res = flip_r ? -y_r : y_r;

    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_SQ1: begin mul_a = 36'(s1_r); mul_b = s1_r[32:0]; end
      B_SQ2: begin mul_a = 36'(s2_r); mul_b = s2_r[32:0]; end
      B_CC:  begin mul_a = 36'(prev_cos_r); mul_b = cos_now_r[32:0]; end
      B_TT:  begin mul_a = 36'(cc_r); mul_b = sq2_r[32:0]; end
      B_TH:  begin mul_a = {5'b0, zc_r}; mul_b = {1'b0, PI_Q30}; end
      B_P1:  begin mul_a = {1'b0, theta_r}; mul_b = {13'b0, radius_r[39:20]}; end
      B_P2:  begin mul_a = {1'b0, theta_r}; mul_b = {13'b0, radius_r[19:0]}; end
      default: ;
    endcase
    prod = mul_a * mul_b;

    h_sum = (CW+1)'(sq1_r) + (CW+1)'(t_r);
    if (h_sum[CW])                       h_cl = '0;
    else if (h_sum > (CW+1)'(QONE))      h_cl = QONE;
    else                                 h_cl = h_sum[30:0];

    ta = ra_r + sbit_r;
    tb = rb_r + sbit_r;

    seg_sum = {1'b0, p1_r} + {21'b0, p2_r[54:20]};
    tot_sum = {1'b0, total_r} + (TOT_W+1)'(seg_r);
    tot_new = !item_r.has_prev ? '0 : (tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      prev_cos_r  <= '0;
      radius_r    <= RADIUS_RESET;
    end else begin
      if (cfg_wr_en) radius_r <= cfg_wr_data;
      if (out_valid_r && out_ready && state_r != B_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_not_empty) begin
            item_r  <= q_item;
            sel_r   <= 2'd0;
            state_r <= B_LOAD;
          end
        end
        B_LOAD: begin
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          z_r     <= CW'(signed'(rot_a2));
          flip_r  <= rot_flip;
          vec_r   <= 1'b0;
          step_r  <= '0;
          state_r <= B_CORD;
        end
        B_CORD: begin
          if (pos) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - ang_t;
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + ang_t;
          end
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_r <= B_CDONE;
        end
        B_CDONE: begin
          if (vec_r) begin
            if (z_r[CW-1])                 zc_r <= '0;
            else if (z_r > CW'(QONE))      zc_r <= QONE;
            else                           zc_r <= z_r[30:0];
            state_r <= B_TH;
          end else begin
            case (sel_r)
              2'd0: begin
                cos_now_r <= c_res;
                if (item_r.has_prev) begin
                  sel_r <= 2'd1; state_r <= B_LOAD;
                end else begin
                  seg_r <= '0; state_r <= B_FIN;
                end
              end
              2'd1: begin s1_r <= s_res; sel_r <= 2'd2; state_r <= B_LOAD; end
              default: begin s2_r <= s_res; state_r <= B_SQ1; end
            endcase
          end
        end
        B_SQ1: begin sq1_r <= prod[63:30]; state_r <= B_SQ2; end
        B_SQ2: begin sq2_r <= prod[63:30]; state_r <= B_CC; end
        B_CC:  begin cc_r  <= prod[63:30]; state_r <= B_TT; end
        B_TT:  begin t_r   <= prod[63:30]; state_r <= B_HC; end
        B_HC: begin
          na_r     <= {3'b0, h_cl, 30'b0};
          nb_r     <= {3'b0, 31'(QONE - h_cl), 30'b0};
          ra_r     <= '0;
          rb_r     <= '0;
          sbit_r   <= 64'h4000_0000_0000_0000;
          sq_cnt_r <= '0;
          state_r  <= B_SQRT;
        end
        B_SQRT: begin
          if (na_r >= ta) begin
            na_r <= na_r - ta; ra_r <= (ra_r >> 1) + sbit_r;
          end else begin
            ra_r <= ra_r >> 1;
          end
          if (nb_r >= tb) begin
            nb_r <= nb_r - tb; rb_r <= (rb_r >> 1) + sbit_r;
          end else begin
            rb_r <= rb_r >> 1;
          end
          sbit_r   <= sbit_r >> 2;
          sq_cnt_r <= sq_cnt_r + 5'd1;
          if (sq_cnt_r == 5'd31) state_r <= B_VLOAD;
        end
        B_VLOAD: begin
          x_r     <= {3'b0, rb_r[30:0]};
          y_r     <= {3'b0, ra_r[30:0]};
          z_r     <= '0;
          vec_r   <= 1'b1;
          step_r  <= '0;
          state_r <= B_CORD;
        end
        B_TH: begin theta_r <= prod[62:28]; state_r <= B_P1; end
        B_P1: begin p1_r <= prod[54:0]; state_r <= B_P2; end
        B_P2: begin p2_r <= prod[54:0]; state_r <= B_SEG; end
        B_SEG: begin seg_r <= {4'b0, seg_sum[55:20]}; state_r <= B_FIN; end
        B_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_seg_r   <= seg_r;
            out_tot_r   <= tot_new;
            out_done_r  <= item_r.last;
            total_r     <= item_r.last ? '0 : tot_new;
            prev_cos_r  <= cos_now_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* sv/haversine_polyline_length.sv */
// ----------------------------------------------------------------------------
// haversine_polyline_length
// Running great-circle length of a polyline of latitude/longitude points.
// ----------------------------------------------------------------------------
// Points enter on in_ch (valid/ready): latitude and longitude in degrees with
// 23 fraction bits, and last_point marking the end of a line. Each point gives
// one transaction on out_ch: segment length to the previous point and running
// total, both with 8 fraction bits, and line_done. The first point of a line
// gives zero; the point after a line_done result starts a new line.
// cfg_wr_en/cfg_wr_data set the sphere radius (16 fraction bits); write it only
// while no point is in flight.
// The back end sets the throughput: it runs three rotations and one vectoring
// pass on one shared CORDIC unit plus 32 square-root steps for a point with a
// predecessor, and one rotation for the first point of a line, and takes the
// next point from the queue only once the last one is in the output register.
// The front end divides by 45 by reciprocal multiplication and overlaps with
// the back end through a two-entry queue.
// Reset clears the previous point, the running total and the queue, and
// loads the earth radius in meters. A stalled receiver holds the result in the
// output register; the back end finishes the next point and then waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_polyline_length import hpl_pkg::*; #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  hpl_in_if.sink           in_ch,
  hpl_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [RAD_W-1:0] cfg_wr_data
);

  logic        push, full, pop, not_empty;
  queue_item_t push_item, pop_item;

  hpl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_latitude   (in_ch.latitude),
    .in_longitude  (in_ch.longitude),
    .in_last_point (in_ch.last_point),
    .push          (push),
    .queue_full    (full),
    .push_item     (push_item)
  );

  hpl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  hpl_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .q_not_empty        (not_empty),
    .q_item             (pop_item),
    .pop                (pop),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_segment_length (out_ch.segment_length),
    .out_total_length   (out_ch.total_length),
    .out_line_done      (out_ch.line_done)
  );

endmodule

/* sv/hpl_checker.sv */
// ----------------------------------------------------------------------------
// hpl_checker
// Port-level checks of the result channel of haversine_polyline_length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "haversine_polyline_length_macros.svh"

module hpl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_segment_length,
  input logic [47:0] out_total_length,
  input logic        out_line_done
);

  logic        start_r;
  logic [47:0] last_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= 1'b1;
      last_total_r <= '0;
    end else if (out_valid && out_ready) begin
      start_r      <= out_line_done;
      last_total_r <= out_total_length;
    end
  end

  `HPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `HPL_ASSERT_IMPL(a_line_start, out_valid && start_r,
                   out_segment_length == 40'd0 && out_total_length == 48'd0)
  `HPL_ASSERT_IMPL(a_total_ge_seg, out_valid,
                   out_total_length >= {8'd0, out_segment_length})
  `HPL_ASSERT_IMPL(a_total_grows, out_valid && !start_r,
                   out_total_length >= last_total_r)

endmodule

bind haversine_polyline_length hpl_checker u_hpl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_segment_length (out_ch.segment_length),
  .out_total_length   (out_ch.total_length),
  .out_line_done      (out_ch.line_done)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the haversine polyline length block.
// ----------------------------------------------------------------------------
// A directed table of points (poles, date line, out-of-range coordinates,
// single-point lines) is followed by random polylines. Most of them are random
// walks and a few are noise points. Every accepted point is run through a
// bit-exact predictor of the CORDIC haversine pipeline. Each result transaction
// is compared with the oldest expectation, a table value or the prediction.
// The sphere radius is rewritten between phases, and each phase uses its own
// mix of sender idling and receiver stalls, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hpl_pkg::*;

  typedef struct {
    bit [SEG_W-1:0] seg;
    bit [TOT_W-1:0] tot;
    bit             done;
  } length_t;

  typedef struct {
    longint lat;
    longint lon;
    bit     last;
    bit     known;
    length_t res;
  } point_row_t;

  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;
  localparam longint Q30     = 1073741824;

  longint step_angle [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [RAD_W-1:0] cfg_wr_data = '0;

  hpl_in_if  in_ch ();
  hpl_out_if out_ch ();

  haversine_polyline_length uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  bit [RAD_W-1:0] radius = RADIUS_RESET;
  longint prev_lat, prev_lon, prev_cos;
  bit has_prev;
  bit [TOT_W-1:0] line_total;

  length_t expected_lengths [$];
  int errors = 0;
  bit in_fired = 1'b0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit cur_known = 1'b0;
  length_t cur_res;

  function automatic bit [31:0] deg_to_angle(longint v, longint mul);
    longint q;
    q = (v * mul) / 45;
    return q[31:0];
  endfunction

  function automatic void cordic_rotate(bit [31:0] a, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= step_angle[i];
      end else begin
        x += ys; y -= xs; z += step_angle[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint square_q30(longint s);
    longint m;
    m = (s < 0) ? -s : s;
    return (m * m) >> 30;
  endfunction

  function automatic bit [63:0] floor_root(bit [63:0] n);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_vector(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += step_angle[i];
      end else begin
        x -= ys; y += xs; z -= step_angle[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Q30) z = Q30;
    return z;
  endfunction

  function automatic length_t predict_length(longint lat, longint lon, bit last);
    length_t r;
    longint cos_now, sin_now, c1, s1, c2, s2, cc, h;
    bit [63:0] a, b, theta, seg, sum;
    seg = 0;
    cordic_rotate(deg_to_angle(lat, 64), cos_now, sin_now);
    if (has_prev) begin
      cordic_rotate(deg_to_angle(lat - prev_lat, 32), c1, s1);
      cordic_rotate(deg_to_angle(lon - prev_lon, 32), c2, s2);
      cc = (prev_cos * cos_now) >>> 30;
      h = square_q30(s1) + ((cc * square_q30(s2)) >>> 30);
      if (h < 0) h = 0;
      if (h > Q30) h = Q30;
      a = floor_root(64'(h) << 30);
      b = floor_root(64'(Q30 - h) << 30);
      theta = (64'(cordic_vector(longint'(b), longint'(a))) * 64'd3373259426) >> 28;
      seg = (theta * 64'(radius >> 20) + ((theta * 64'(radius[19:0])) >> 20)) >> 20;
      if (seg > 64'hFF_FFFF_FFFF) seg = 64'hFF_FFFF_FFFF;
      sum = 64'(line_total) + seg;
      if (sum > 64'hFFFF_FFFF_FFFF) sum = 64'hFFFF_FFFF_FFFF;
      line_total = sum[TOT_W-1:0];
    end else begin
      line_total = 0;
    end
    r.seg = seg[SEG_W-1:0];
    r.tot = line_total;
    r.done = last;
    has_prev = !last;
    if (last) line_total = 0;
    prev_lat = lat;
    prev_lon = lon;
    prev_cos = cos_now;
    return r;
  endfunction

  always @(posedge clk) begin
    length_t p;
    in_fired <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p = predict_length(longint'(in_ch.latitude), longint'(in_ch.longitude),
                         in_ch.last_point);
      expected_lengths.push_back(cur_known ? cur_res : p);
    end
  end

  always @(posedge clk) begin
    length_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_lengths.size() == 0) begin
        $display("%0t unexpected result seg=%h tot=%h done=%b", $time,
                 out_ch.segment_length, out_ch.total_length, out_ch.line_done);
        errors++;
      end else begin
        e = expected_lengths.pop_front();
        if (out_ch.segment_length !== e.seg || out_ch.total_length !== e.tot ||
            out_ch.line_done !== e.done) begin
          $display("%0t mismatch expected seg=%h tot=%h done=%b actual seg=%h tot=%h done=%b",
                   $time, e.seg, e.tot, e.done, out_ch.segment_length,
                   out_ch.total_length, out_ch.line_done);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_point(longint lat, longint lon, bit last, bit known, length_t res);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.latitude = lat[30:0];
    in_ch.longitude = lon[31:0];
    in_ch.last_point = last;
    cur_known = known;
    cur_res = res;
    do @(negedge clk); while (!in_fired);
    cur_known = 1'b0;
  endtask

  task automatic write_radius(bit [RAD_W-1:0] r);
    in_ch.valid = 1'b0;
    while (expected_lengths.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = r;
    radius = r;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic random_phase(int n_items);
    longint lat, lon, span;
    int len, k;
    length_t none;
    k = 0;
    while (k < n_items) begin
      len = $urandom_range(1, 12);
      lat = longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
      lon = longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
      case ($urandom_range(2))
        0: span = 1000;
        1: span = 8388608;
        default: span = 8388608 * 40;
      endcase
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(19) == 0) begin
          lat = longint'(signed'(31'($urandom())));
          lon = longint'(signed'($urandom()));
        end else if (j > 0) begin
          lat = clamp(lat + longint'($urandom_range(0, 2 * span)) - span, LAT_MAX);
          lon = clamp(lon + longint'($urandom_range(0, 2 * span)) - span, LON_MAX);
        end
        send_point(lat, lon, j == len - 1 || $urandom_range(30) == 0, 1'b0, none);
        k++;
      end
    end
  endtask

  point_row_t directed [] = '{
    '{0, 0, 1, 1, '{0, 0, 1}},
    '{0, 0, 0, 1, '{0, 0, 0}},
    '{0, 0, 0, 0, '{0, 0, 0}},
    '{754974720, 0, 0, 0, '{0, 0, 0}},
    '{-754974720, 0, 0, 0, '{0, 0, 0}},
    '{0, 1509949440, 0, 0, '{0, 0, 0}},
    '{0, -1509949440, 0, 0, '{0, 0, 0}},
    '{754974720, 1509949440, 0, 0, '{0, 0, 0}},
    '{-754974720, -1509949440, 1, 0, '{0, 0, 0}},
    '{12345, 67890, 1, 1, '{0, 0, 1}},
    '{-1073741824, -2147483648, 0, 1, '{0, 0, 0}},
    '{1073741823, 2147483647, 0, 0, '{0, 0, 0}},
    '{1, 1, 0, 0, '{0, 0, 0}},
    '{0, 0, 0, 0, '{0, 0, 0}},
    '{-1, -1, 1, 0, '{0, 0, 0}},
    '{419430400, -838860800, 0, 1, '{0, 0, 0}},
    '{419430401, -838860800, 1, 0, '{0, 0, 0}}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.latitude = '0;
    in_ch.longitude = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
    prev_lat = 0;
    prev_lon = 0;
    prev_cos = 0;
    has_prev = 1'b0;
    line_total = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_point(directed[i].lat, directed[i].lon, directed[i].last,
                 directed[i].known, directed[i].res);

    hold_left = 3000;
    random_phase(410);
    write_radius(40'hFF_FFFF_FFFF);
    foreach (directed[i])
      send_point(directed[i].lat, directed[i].lon, directed[i].last, 1'b0, cur_res);
    send_idle = 78;
    random_phase(400);
    write_radius(40'd1);
    send_idle = 0;
    recv_stall = 78;
    random_phase(400);
    write_radius(40'($urandom()) << $urandom_range(0, 8));
    send_idle = 13;
    recv_stall = 13;
    random_phase(400);

    in_ch.valid = 1'b0;
    while (expected_lengths.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/hpl_pkg.sv
sv/hpl_if.sv
sv/hpl_front.sv
sv/hpl_queue.sv
sv/hpl_back.sv
sv/haversine_polyline_length.sv
sv/hpl_checker.sv
tb/testbench.sv
